// ===== rtl/bounded_set_table_unit_macros.svh =====
// Assertion macros shared by the checker of the bounded set table.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef BOUNDED_SET_TABLE_UNIT_MACROS_SVH
`define BOUNDED_SET_TABLE_UNIT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset
`define BST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define BST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bst_pkg.sv =====
// Shared types and constants of the bounded set table.
// No dependencies; imported by the cell, the top level and the checker.
package bst_pkg;

   // Default number of cells (entries the set can hold)
   localparam int SET_CAPACITY_DEFAULT = 64;

   // Field widths of the request and response transfers
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 7;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

   // Update strobes broadcast to every cell
   typedef struct packed {
      logic ins_en;   // write the key into the cell at the fill position
      logic del_en;   // cells at or above the hit take their upper neighbour
   } cell_ctl_type;

endpackage

// ===== rtl/bst_cell.sv =====
// One storage cell of the bounded set table: holds one value, compares it
// with the broadcast key and shifts down on delete. Uses bst_pkg.
module bst_cell #(
   parameter int COUNT_W = 7,
   parameter int INDEX   = 0
) (
   input  logic                               clock,
   input  bst_pkg::cell_ctl_type              ctl,
   input  logic [bst_pkg::VALUE_W-1:0]        key,
   input  logic [COUNT_W-1:0]                 count,
   input  logic [bst_pkg::VALUE_W-1:0]        upper_data,
   input  logic                               seen_in,
   output logic [bst_pkg::VALUE_W-1:0]        data,
   output logic                               seen_out
);
   import bst_pkg::*;

   localparam logic [COUNT_W-1:0] IDX = COUNT_W'(INDEX);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;
   logic               occupied;
   logic               hit;

   // Only cells below the fill count hold a live value
   assign occupied = IDX < count;
   assign hit      = occupied && (data_ff == key);
   assign seen_out = seen_in | hit;
   assign data     = data_ff;

   // Append at the fill position, or close the gap on delete
   always_comb begin
      data_in = data_ff;
      if (ctl.ins_en && (IDX == count)) begin
         data_in = key;
      end else if (ctl.del_en && seen_out) begin
         data_in = upper_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== rtl/bounded_set_table_unit.sv =====
// Bounded set table: a set of up to SET_CAPACITY distinct 32-bit values in
// insertion order, held in a row of cells that each store one value and
// compare it with the key in parallel. Each item is taken from the request
// transfer into the operation register in S_IDLE; then, in S_EXEC, all cells
// compare, the hit is chained along the row and the row updates (append at
// the fill position, or shift down over a deleted value). The next request
// is taken once that update is done, so one item is in flight at a time.
// A finished response waits in an output register; a new request is taken
// while it is stalled, and the update cycle waits only if the previous
// response is still untaken. entry_total shows the low 7 bits of the count.
module bounded_set_table_unit #(
   parameter int SET_CAPACITY = bst_pkg::SET_CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bst_pkg::KIND_W-1:0]           req_kind,
   input  logic signed [bst_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bst_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bst_pkg::TOTAL_W-1:0]          rsp_entry_total,
   output logic                                 rsp_vacant
);
   import bst_pkg::*;

   localparam int COUNT_W = $clog2(SET_CAPACITY + 1);
   localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(SET_CAPACITY);

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type            state_ff;
   logic [KIND_W-1:0]    kind_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic [STATUS_W-1:0]  status_ff;
   logic [STATUS_W-1:0]  status_in;
   logic [TOTAL_W-1:0]   total_ff;
   logic [TOTAL_W-1:0]   total_in;
   logic                 empty_ff;
   logic                 rsp_valid_ff;
   logic                 exec_go;
   logic                 full;
   logic                 found;
   cell_ctl_type         ctl;

   logic [VALUE_W-1:0]   cell_data [SET_CAPACITY];
   logic [SET_CAPACITY:0] seen;

   // Row of cells; the hit flag ripples upwards, data moves downwards
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] upper;
      if (i == SET_CAPACITY - 1) begin : g_top
         assign upper = cell_data[i];
      end else begin : g_mid
         assign upper = cell_data[i+1];
      end
      bst_cell #(
         .COUNT_W (COUNT_W),
         .INDEX   (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key        (value_ff),
         .count      (count_ff),
         .upper_data (upper),
         .seen_in    (seen[i]),
         .data       (cell_data[i]),
         .seen_out   (seen[i+1])
      );
   end

   assign found   = seen[SET_CAPACITY];
   assign full    = count_ff >= CAP_C;
   assign exec_go = (state_ff == S_EXEC) && !(rsp_valid_ff && rsp_stall);

   // Update strobes for the row
   assign ctl.ins_en = exec_go && (kind_ff == KIND_INSERT) && !full && !found;
   assign ctl.del_en = exec_go && (kind_ff == KIND_DELETE);

   // Status and new count of the item in flight
   always_comb begin
      status_in = ST_DONE;
      count_in  = count_ff;
      case (kind_ff)
         KIND_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (found) begin
               status_in = ST_PRESENT;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         KIND_DELETE: begin
            if (!found) begin
               status_in = ST_ABSENT;
            end else begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         KIND_QUERY: begin
            if (!found) begin
               status_in = ST_ABSENT;
            end
         end
         KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   // Reported count is the low bits of the internal one
   if (COUNT_W >= TOTAL_W) begin : g_tot_trunc
      assign total_in = count_in[TOTAL_W-1:0];
   end else begin : g_tot_ext
      assign total_in = {{(TOTAL_W - COUNT_W){1'b0}}, count_in};
   end

   // Sequencer, count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff  <= req_kind;
                  value_ff <= req_value;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (exec_go) begin
                  count_ff     <= count_in;
                  status_ff    <= status_in;
                  total_ff     <= total_in;
                  empty_ff     <= (count_in == '0);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // No request is taken while reset is held
   assign req_stall       = reset || (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_total = total_ff;
   assign rsp_vacant      = empty_ff;

endmodule

// ===== rtl/bst_checker.sv =====
// Port-level checks for the bounded set table, bound to the top level.
// Uses bst_pkg and the assertion macros header.
`include "bounded_set_table_unit_macros.svh"

module bst_checker #(
   parameter int SET_CAPACITY = bst_pkg::SET_CAPACITY_DEFAULT
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [bst_pkg::STATUS_W-1:0]         rsp_status,
   input logic [bst_pkg::TOTAL_W-1:0]          rsp_entry_total,
   input logic                                 rsp_vacant
);
   import bst_pkg::*;

   logic req_xfer;
   logic rsp_held;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   // One item at a time: busy in the cycle after a request transfer
   `BST_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, req_stall, "request taken while busy")

   // Response follows a request transfer taken while no response was stalled
   `BST_ASSERT(a_rsp_latency, clock, reset, (req_xfer && !rsp_held) |-> ##2 rsp_valid, "response missing")

   // Empty flag agrees with the reported count
   `BST_ASSERT(a_empty_flag, clock, reset, rsp_valid |-> ((rsp_vacant == (rsp_entry_total == '0)) || (SET_CAPACITY > 127)), "empty flag and count disagree")

   // A stalled response holds
   `BST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_total) && $stable(rsp_vacant), "stalled response changed")

endmodule

bind bounded_set_table_unit bst_checker #(
   .SET_CAPACITY (SET_CAPACITY)
) u_bst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_entry_total (rsp_entry_total),
   .rsp_vacant      (rsp_vacant)
);

// ===== verif/tb_bounded_set_table_unit.sv =====
// Testbench for bounded_set_table_unit: a directed table, then random insert,
// delete, query and clear traffic, each response checked against a predictor or a table entry.
// Depends on bst_pkg and the bounded_set_table_unit RTL only.
module tb_bounded_set_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bst_pkg::*;

   localparam int SET_CAP     = SET_CAPACITY_DEFAULT;
   localparam int VALUE_POOL  = 96;
   localparam int SEGMENTS    = 7;
   localparam int SEG_ITEMS   = 138;
   localparam int STUCK_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  total;
      logic                empty;
   } set_reply_type;

   // One directed row; copies > 1 steps the value by one per transfer
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [VALUE_W-1:0]  value;
      logic [7:0]          copies;
      logic                typed;
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  total;
      logic                empty;
   } stim_row_type;

   localparam logic [TOTAL_W-1:0] FULL_TOTAL = TOTAL_W'(SET_CAP);
   localparam logic [TOTAL_W-1:0] LESS_ONE   = TOTAL_W'(SET_CAP - 1);

   localparam stim_row_type DIRECTED [25] = '{
      // empty set straight after reset
      '{KIND_QUERY,  32'h0000_0000, 8'd1, 1'b1, ST_ABSENT,  7'd0, 1'b1},
      '{KIND_DELETE, 32'h8000_0000, 8'd1, 1'b1, ST_ABSENT,  7'd0, 1'b1},
      '{KIND_CLEAR,  32'hFFFF_FFFF, 8'd1, 1'b1, ST_DONE,    7'd0, 1'b1},
      // value extremes, duplicate insert, hits and misses
      '{KIND_INSERT, 32'h8000_0000, 8'd1, 1'b1, ST_DONE,    7'd1, 1'b0},
      '{KIND_INSERT, 32'h7FFF_FFFF, 8'd1, 1'b1, ST_DONE,    7'd2, 1'b0},
      '{KIND_INSERT, 32'h0000_0000, 8'd1, 1'b1, ST_DONE,    7'd3, 1'b0},
      '{KIND_INSERT, 32'h7FFF_FFFF, 8'd1, 1'b1, ST_PRESENT, 7'd3, 1'b0},
      '{KIND_QUERY,  32'hFFFF_FFFF, 8'd1, 1'b1, ST_ABSENT,  7'd3, 1'b0},
      '{KIND_QUERY,  32'h8000_0000, 8'd1, 1'b1, ST_DONE,    7'd3, 1'b0},
      // delete from the middle, then the shifted entry must still be found
      '{KIND_DELETE, 32'h7FFF_FFFF, 8'd1, 1'b1, ST_DONE,    7'd2, 1'b0},
      '{KIND_QUERY,  32'h0000_0000, 8'd1, 1'b1, ST_DONE,    7'd2, 1'b0},
      '{KIND_INSERT, 32'hFFFF_FFFF, 8'd1, 1'b1, ST_DONE,    7'd3, 1'b0},
      '{KIND_DELETE, 32'hFFFF_FFFF, 8'd1, 1'b1, ST_DONE,    7'd2, 1'b0},
      '{KIND_DELETE, 32'h8000_0000, 8'd1, 1'b1, ST_DONE,    7'd1, 1'b0},
      '{KIND_DELETE, 32'h0000_0000, 8'd1, 1'b1, ST_DONE,    7'd0, 1'b1},
      '{KIND_INSERT, 32'h0000_0001, 8'd1, 1'b1, ST_DONE,    7'd1, 1'b0},
      '{KIND_CLEAR,  32'h1234_5678, 8'd1, 1'b1, ST_DONE,    7'd0, 1'b1},
      // fill to capacity; full wins over already present
      '{KIND_INSERT, 32'h0000_1000, 8'(SET_CAP), 1'b0, ST_DONE, 7'd0, 1'b0},
      '{KIND_INSERT, 32'h0000_1000, 8'd1, 1'b1, ST_FULL,    FULL_TOTAL, 1'b0},
      '{KIND_INSERT, 32'h5555_AAAA, 8'd1, 1'b1, ST_FULL,    FULL_TOTAL, 1'b0},
      '{KIND_QUERY,  32'h0000_103F, 8'd1, 1'b1, ST_DONE,    FULL_TOTAL, 1'b0},
      '{KIND_DELETE, 32'h0000_1000, 8'd1, 1'b1, ST_DONE,    LESS_ONE,   1'b0},
      '{KIND_INSERT, 32'hAAAA_5555, 8'd1, 1'b1, ST_DONE,    FULL_TOTAL, 1'b0},
      '{KIND_DELETE, 32'hAAAA_5555, 8'd1, 1'b1, ST_DONE,    LESS_ONE,   1'b0},
      '{KIND_CLEAR,  32'h0000_0000, 8'd1, 1'b1, ST_DONE,    7'd0, 1'b1}
   };

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic [KIND_W-1:0]          req_kind  = KIND_QUERY;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       rsp_stall = 1'b0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic [TOTAL_W-1:0]         rsp_entry_total;
   logic                       rsp_vacant;

   // Predictor state: held values in insertion order
   logic [VALUE_W-1:0] held_values [SET_CAP];
   int                 held_count = 0;

   set_reply_type      pending_replies [$];
   logic [VALUE_W-1:0] value_pool [VALUE_POOL];
   int                 error_count  = 0;
   int                 stuck_cycles = 0;
   int                 stall_left   = 0;
   bit                 req_idling   = 1'b0;
   bit                 rsp_idling   = 1'b0;
   set_reply_type      want;

   bounded_set_table_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_total (rsp_entry_total),
      .rsp_vacant      (rsp_vacant)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Position of a value among the held entries, -1 when absent
   function automatic int locate_value(input logic [VALUE_W-1:0] value);
      for (int i = 0; i < held_count; i++) begin
         if (held_values[i] == value) return i;
      end
      return -1;
   endfunction

   // Apply one operation to the predicted set and return its response
   function automatic set_reply_type apply_set_op(input logic [KIND_W-1:0] kind,
                                                  input logic [VALUE_W-1:0] value);
      set_reply_type reply;
      int            pos;
      reply.status = ST_DONE;
      case (kind)
         KIND_INSERT: begin
            if (held_count >= SET_CAP) reply.status = ST_FULL;
            else if (locate_value(value) >= 0) reply.status = ST_PRESENT;
            else begin
               held_values[held_count] = value;
               held_count++;
            end
         end
         KIND_DELETE: begin
            pos = locate_value(value);
            if (pos < 0) reply.status = ST_ABSENT;
            else begin
               // close the gap so insertion order is kept
               for (int i = pos; i + 1 < held_count; i++) held_values[i] = held_values[i + 1];
               held_count--;
            end
         end
         KIND_QUERY: begin
            if (locate_value(value) < 0) reply.status = ST_ABSENT;
         end
         default: begin
            held_count = 0;
         end
      endcase
      reply.total = TOTAL_W'(held_count);
      reply.empty = (held_count == 0);
      return reply;
   endfunction

   // Drive one request transfer, optionally after an idle burst
   task automatic transfer_request(input logic [KIND_W-1:0] kind,
                                   input logic [VALUE_W-1:0] value,
                                   input bit typed, input set_reply_type typed_reply);
      set_reply_type reply;
      if (req_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      reply = apply_set_op(kind, value);
      pending_replies.push_back(typed ? typed_reply : reply);
   endtask

   task automatic check_field(input string field, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field, exp_val, act_val);
         error_count++;
      end
   endtask

   // Response side: check accepted transfers, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: response with none outstanding, status %0d total %0d vacant %0d",
                     $time, rsp_status, rsp_entry_total, rsp_vacant);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("entry_total", 32'(want.total), 32'(rsp_entry_total));
            check_field("vacant", 32'(want.empty), 32'(rsp_vacant));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("tb_bounded_set_table_unit: errors");
      $finish;
   end

   initial begin
      stim_row_type       row;
      set_reply_type      typed_reply;
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      int                 pick;
      int                 ins_cut;
      int                 del_cut;

      // value pool: random patterns plus the extremes
      for (int i = 0; i < VALUE_POOL; i++) value_pool[i] = $urandom;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      foreach (DIRECTED[r]) begin
         row = DIRECTED[r];
         typed_reply = '{status: row.status, total: row.total, empty: row.empty};
         for (int c = 0; c < row.copies; c++)
            transfer_request(row.kind, row.value + c, row.typed, typed_reply);
      end

      // random traffic; even segments lean on insert so the set fills up
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         req_idling = (seg != 3) && (seg != SEGMENTS - 1);
         rsp_idling = req_idling;
         ins_cut = (seg % 2 == 0) ? 70 : 40;
         del_cut = (seg % 2 == 0) ? 85 : 70;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 1) kind = KIND_CLEAR;
            else if (pick < ins_cut) kind = KIND_INSERT;
            else if (pick < del_cut) kind = KIND_DELETE;
            else kind = KIND_QUERY;
            if ($urandom_range(0, 9) == 0) value = $urandom;
            else value = value_pool[$urandom_range(0, VALUE_POOL - 1)];
            transfer_request(kind, value, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_bounded_set_table_unit: clean");
      end else begin
         $display("tb_bounded_set_table_unit: errors");
      end
      $finish;
   end

endmodule
